>>> src/sqm_pkg.sv
// Shared types, codes and field widths of the square matrix add/subtract/multiply core.
package sqm_pkg;

  localparam int ELEM_W     = 32;
  localparam int IDX_W      = 3;
  localparam int SIZE_W     = 4;
  localparam int MODE_W     = 2;
  localparam int REQ_W      = 2;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;

  // Request codes carried on the input tuser.
  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN    = 2'd2;

  // Operation codes held in the mode register.
  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } sqm_state_t;

  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic              rd_valid;
    logic              first;
    logic              lastk;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  k;
    logic              last_elem;
  } sqm_cmd_t;

  typedef struct packed {
    logic busy;
  } sqm_stat_t;

endpackage

>>> src/square_matrix_add_sub_mul_core.sv
// Load transfers are taken one per cycle while idle and write the store at that edge.
// Each result element of a multiply run takes N term reads, two pipeline stages, one output
// transfer and one step to the next element; add/subtract reads a single term per element.
// The term loop over the single read port of each store sets the rate.
// No input is taken during a run.
// Reset (synchronous, active low) sets size 8, mode add, idles; the stores keep contents.
module square_matrix_add_sub_mul_core #(
  parameter int MAX_SIZE = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port; no read-back.
  input  logic                             cfg_we,
  input  logic [sqm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sqm_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Request stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata from bit 0: row_index[2:0], col_index[5:3], elem_value[37:6], zero fill.
  input  logic [sqm_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: req_type[1:0].
  input  logic [sqm_pkg::REQ_W-1:0]        in_tuser,
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata from bit 0: out_row[2:0], out_col[5:3], result_value[37:6], zero fill.
  output logic [sqm_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast
);
  import sqm_pkg::*;

  sqm_cmd_t          cmd_s;
  sqm_stat_t         stat_s;
  logic [IDX_W-1:0]  in_row, in_col, res_row, res_col;
  logic [ELEM_W-1:0] in_value, res_value;

  // Unpack the request transfer.
  assign in_row   = in_tdata[IDX_W-1:0];
  assign in_col   = in_tdata[2*IDX_W-1:IDX_W];
  assign in_value = in_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];

  // The controller owns the registers and sequences rows, columns and terms.
  sqm_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser),
    .in_row    (in_row),
    .in_col    (in_col),
    .cmd       (cmd_s),
    .stat      (stat_s)
  );

  // The datapath holds both stores, computes each term and accumulates it.
  sqm_datapath #(.MAX_SIZE(MAX_SIZE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_s),
    .stat      (stat_s),
    .wr_row    (in_row),
    .wr_col    (in_col),
    .wr_data   (in_value),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_row   (res_row),
    .out_col   (res_col),
    .out_value (res_value),
    .out_last  (out_tlast)
  );

  // Pack the result transfer, zero filled to whole bytes.
  assign out_tdata = {{(OUT_DATA_W - 2*IDX_W - ELEM_W){1'b0}}, res_value, res_col, res_row};

`ifndef SYNTHESIS
  // Requests are only taken with the pipeline and output register empty.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat_s.busy)
    else $error("request accepted while results are still in flight");

  // Store reads never overlap the cycles in which loads may write.
  a_no_read_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_s.rd_valid |-> !in_tready)
    else $error("store read issued while requests are accepted");

  // After the final result transfer the block returns to taking requests.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |-> ##2 in_tready)
    else $error("block did not return to idle after the final result");
`endif

endmodule

>>> src/sqm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sqm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/sqm_ctrl.sv
// Controller: configuration registers, request decode and the element/term sequencer.
module sqm_ctrl #(
  parameter int MAX_SIZE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sqm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sqm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sqm_pkg::REQ_W-1:0]       in_req,
  input  logic [sqm_pkg::IDX_W-1:0]       in_row,
  input  logic [sqm_pkg::IDX_W-1:0]       in_col,
  output sqm_pkg::sqm_cmd_t               cmd,
  input  sqm_pkg::sqm_stat_t              stat
);
  import sqm_pkg::*;

  localparam logic [SIZE_W-1:0] MAX_N = SIZE_W'(MAX_SIZE);

  sqm_state_t        state_r, state_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [SIZE_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0]  r_r, r_nxt;
  logic [IDX_W-1:0]  c_r, c_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;

  logic [SIZE_W-1:0] n_sat;
  logic [SIZE_W-1:0] n_m1_full;
  logic [IDX_W-1:0]  n_m1;
  logic [IDX_W-1:0]  kmax;
  logic              in_range;
  logic              accept;
  logic              last_elem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      size_r  <= SIZE_RESET;
      mode_r  <= MODE_RESET;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    r_r <= r_nxt;
    c_r <= c_nxt;
    k_r <= k_nxt;
  end

  always_comb begin
    size_nxt = size_r;
    mode_nxt = mode_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MATRIX_SIZE: size_nxt = cfg_data;
        CFG_OP_MODE:     mode_nxt = cfg_data[MODE_W-1:0];
        default:         ;
      endcase
    end
  end

  assign n_sat     = (size_r > MAX_N) ? MAX_N : size_r;
  assign n_m1_full = n_r - SIZE_W'(1);
  assign n_m1      = n_m1_full[IDX_W-1:0];
  assign kmax      = (mode_r == MODE_MUL) ? n_m1 : '0;
  assign in_range  = ({1'b0, in_row} < MAX_N) && ({1'b0, in_col} < MAX_N);
  assign accept    = in_valid && in_ready;
  assign last_elem = (r_r == n_m1) && (c_r == n_m1);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;

    cmd           = '0;
    cmd.mode      = mode_r;
    cmd.row       = r_r;
    cmd.col       = c_r;
    cmd.k         = k_r;
    cmd.first     = (k_r == '0);
    cmd.lastk     = (k_r == kmax);
    cmd.last_elem = last_elem;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          case (in_req)
            REQ_LOAD_A: cmd.we_a = in_range;
            REQ_LOAD_B: cmd.we_b = in_range;
            REQ_RUN: begin
              if (n_sat != '0) begin
                n_nxt     = n_sat;
                r_nxt     = '0;
                c_nxt     = '0;
                k_nxt     = '0;
                state_nxt = ST_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.rd_valid = 1'b1;
        if (k_r == kmax) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // Move on once the finished element has left the output register.
        if (!stat.busy) begin
          if (last_elem) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = '0;
            state_nxt = ST_ISSUE;
            if (c_r == n_m1) begin
              c_nxt = '0;
              r_nxt = r_r + IDX_W'(1);
            end else begin
              c_nxt = c_r + IDX_W'(1);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> src/sqm_datapath.sv
// Datapath: A and B element stores, operand stage, accumulator and output register.
module sqm_datapath #(
  parameter int MAX_SIZE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sqm_pkg::sqm_cmd_t             cmd,
  output sqm_pkg::sqm_stat_t            stat,
  input  logic [sqm_pkg::IDX_W-1:0]     wr_row,
  input  logic [sqm_pkg::IDX_W-1:0]     wr_col,
  input  logic [sqm_pkg::ELEM_W-1:0]    wr_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sqm_pkg::IDX_W-1:0]     out_row,
  output logic [sqm_pkg::IDX_W-1:0]     out_col,
  output logic [sqm_pkg::ELEM_W-1:0]    out_value,
  output logic                          out_last
);
  import sqm_pkg::*;

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [ELEM_W-1:0] a_q, b_q;
  logic [IDX_W-1:0]  a_col, b_row;

  logic              v1_r, first1_r, last1_r;
  logic              v2_r, first2_r, last2_r;
  logic [ELEM_W-1:0] term_r, term_nxt;
  logic [ELEM_W-1:0] acc_r, acc_nxt;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic [ELEM_W-1:0] out_value_r;
  logic              out_last_r;

  assign a_col   = (cmd.mode == MODE_MUL) ? cmd.k : cmd.col;
  assign b_row   = (cmd.mode == MODE_MUL) ? cmd.k : cmd.row;
  assign waddr   = AW'(int'(wr_row) * MAX_SIZE + int'(wr_col));
  assign raddr_a = AW'(int'(cmd.row) * MAX_SIZE + int'(a_col));
  assign raddr_b = AW'(int'(b_row) * MAX_SIZE + int'(cmd.col));

  sqm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH), .AW(AW)) u_ram_a (
    .clk   (clk),
    .we    (cmd.we_a),
    .waddr (waddr),
    .wdata (wr_data),
    .raddr (raddr_a),
    .rdata (a_q)
  );

  sqm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH), .AW(AW)) u_ram_b (
    .clk   (clk),
    .we    (cmd.we_b),
    .waddr (waddr),
    .wdata (wr_data),
    .raddr (raddr_b),
    .rdata (b_q)
  );

  // Unused mode code falls through to add.
  always_comb begin
    case (cmd.mode)
      MODE_SUB: term_nxt = a_q - b_q;
      MODE_MUL: term_nxt = ELEM_W'(a_q * b_q);
      default:  term_nxt = a_q + b_q;
    endcase
  end

  assign acc_nxt = first2_r ? term_r : (acc_r + term_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_valid;
      v2_r <= v1_r;
      if (v2_r && last2_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= cmd.first;
    last1_r  <= cmd.lastk;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    term_r   <= term_nxt;
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
    if (v2_r && last2_r) begin
      out_value_r <= acc_nxt;
      out_row_r   <= cmd.row;
      out_col_r   <= cmd.col;
      out_last_r  <= cmd.last_elem;
    end
  end

  assign stat.busy = v1_r || v2_r || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

>>> tb/sv/sqm_result_checker.sv
// Checker that predicts the matrix core's results from its channel traffic and compares them.
module sqm_result_checker #(
  parameter int MAX_SIZE = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sqm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sqm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [sqm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [sqm_pkg::REQ_W-1:0]      in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [sqm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tlast,
  output int unsigned                    pending_elems,
  output int unsigned                    mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import sqm_pkg::*;

  localparam int COL_LSB = IDX_W;
  localparam int VAL_LSB = 2 * IDX_W;

  typedef struct {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] value;
    logic              last;
  } matrix_elem_t;

  logic [ELEM_W-1:0] store_a [MAX_SIZE*MAX_SIZE];
  logic [ELEM_W-1:0] store_b [MAX_SIZE*MAX_SIZE];
  logic [SIZE_W-1:0] cur_size;
  logic [MODE_W-1:0] cur_mode;
  matrix_elem_t      expected_elems [$];

  initial begin
    pending_elems  = 0;
    mismatch_count = 0;
  end

  // One element of the result matrix under the current mode; all sums wrap at 32 bits.
  function automatic logic [ELEM_W-1:0] matrix_element(int r, int c, int n);
    logic [ELEM_W-1:0] acc;
    acc = '0;
    case (cur_mode)
      MODE_SUB: acc = store_a[r*MAX_SIZE+c] - store_b[r*MAX_SIZE+c];
      MODE_MUL: begin
        for (int k = 0; k < n; k++) begin
          acc = acc + store_a[r*MAX_SIZE+k] * store_b[k*MAX_SIZE+c];
        end
      end
      // The unused mode code falls back to addition.
      default: acc = store_a[r*MAX_SIZE+c] + store_b[r*MAX_SIZE+c];
    endcase
    return acc;
  endfunction

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    matrix_elem_t      want;
    logic [IDX_W-1:0]  got_row;
    logic [IDX_W-1:0]  got_col;
    logic [ELEM_W-1:0] got_value;
    int                addr;
    int                n;
    if (!rst_n) begin
      cur_size = SIZE_RESET;
      cur_mode = MODE_RESET;
      expected_elems.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MATRIX_SIZE) begin
          cur_size = cfg_data[SIZE_W-1:0];
        end else if (cfg_index == CFG_OP_MODE) begin
          cur_mode = cfg_data[MODE_W-1:0];
        end
      end

      if (out_tvalid && out_tready) begin
        got_row   = out_tdata[IDX_W-1:0];
        got_col   = out_tdata[COL_LSB+IDX_W-1:COL_LSB];
        got_value = out_tdata[VAL_LSB+ELEM_W-1:VAL_LSB];
        if (expected_elems.size() == 0) begin
          log_mismatch($sformatf("unexpected result row %0d col %0d value %08h last %0b",
                                 got_row, got_col, got_value, out_tlast));
        end else begin
          want = expected_elems.pop_front();
          if (got_row !== want.row || got_col !== want.col ||
              got_value !== want.value || out_tlast !== want.last) begin
            log_mismatch($sformatf({"result mismatch: expected row %0d col %0d value %08h ",
                                    "last %0b, got row %0d col %0d value %08h last %0b"},
              want.row, want.col, want.value, want.last,
              got_row, got_col, got_value, out_tlast));
          end
        end
      end

      if (in_tvalid && in_tready) begin
        addr = int'(in_tdata[IDX_W-1:0]) * MAX_SIZE + int'(in_tdata[COL_LSB+IDX_W-1:COL_LSB]);
        case (in_tuser)
          REQ_LOAD_A: store_a[addr] = in_tdata[VAL_LSB+ELEM_W-1:VAL_LSB];
          REQ_LOAD_B: store_b[addr] = in_tdata[VAL_LSB+ELEM_W-1:VAL_LSB];
          REQ_RUN: begin
            // Sizes above the store dimension saturate; size zero yields nothing.
            n = (cur_size > MAX_SIZE) ? MAX_SIZE : int'(cur_size);
            for (int r = 0; r < n; r++) begin
              for (int c = 0; c < n; c++) begin
                want.row   = IDX_W'(r);
                want.col   = IDX_W'(c);
                want.value = matrix_element(r, c, n);
                want.last  = (r == n - 1) && (c == n - 1);
                expected_elems.push_back(want);
              end
            end
          end
          default: ;
        endcase
      end
    end
    pending_elems = expected_elems.size();
  end

endmodule

>>> tb/sv/square_matrix_add_sub_mul_core_tb.sv
// Testbench top for the square matrix add/subtract/multiply core: stimulus, flow control, verdict.
module square_matrix_add_sub_mul_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sqm_pkg::*;

  localparam int DIM = 8;
  // Cycles to let pass once no result is pending; covers the run pipeline after the last element.
  localparam int SETTLE_CYCLES = 20;
  // Length of the deliberate long receiver stall.
  localparam int HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 110;

  // Codes the package leaves unnamed; the core must ignore the request and add for the mode.
  localparam logic [REQ_W-1:0]  REQ_UNUSED  = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [ELEM_W-1:0] ELEM_MAX  = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] ELEM_MIN  = 32'h8000_0000;
  localparam logic [ELEM_W-1:0] ELEM_NEG1 = 32'hFFFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // in_tdata from bit 0: row_index[2:0], col_index[5:3], elem_value[37:6], zero fill.
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // in_tuser: req_type[1:0].
  logic [REQ_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata from bit 0: out_row[2:0], out_col[5:3], result_value[37:6], zero fill.
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int unsigned pending_elems;
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;

  // Which store elements have been loaded; a run never touches an element that is still unset.
  bit loaded_a [DIM*DIM];
  bit loaded_b [DIM*DIM];
  // Loads and runs taken by the core; ignored requests do not count.
  int sent_items = 0;
  // When set, neither side inserts idle cycles for the current phase.
  bit steady_flow = 1'b0;
  // Handshake between the stimulus and the receiver for the one long output stall.
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always #5 clk = ~clk;

  square_matrix_add_sub_mul_core #(
    .MAX_SIZE (DIM)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  sqm_result_checker #(
    .MAX_SIZE (DIM)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .pending_elems  (pending_elems),
    .mismatch_count (mismatch_count)
  );

  // Idle gap before a transfer: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Element values lean toward the corners of the signed range, where wrapping shows.
  function automatic logic [ELEM_W-1:0] random_elem();
    case ($urandom_range(0, 9))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return ELEM_NEG1;
      3: return '0;
      4, 5: return ELEM_W'($urandom_range(0, 32)) - ELEM_W'(16);
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  // Mostly small matrices; the largest ones are slow in multiply mode.
  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll < 5) return SIZE_W'($urandom_range(1, 2));
    if (roll < 8) return SIZE_W'($urandom_range(3, 4));
    if (roll < 9) return SIZE_W'($urandom_range(5, 6));
    return SIZE_W'($urandom_range(7, DIM));
  endfunction

  // Offers one request and returns at the edge where it transfers. Called right after a
  // rising edge; in_tvalid stays high so a following call can present the next request
  // back to back, and whoever stops sending must lower it.
  task automatic send_req(logic [REQ_W-1:0] req, logic [IDX_W-1:0] row,
                          logic [IDX_W-1:0] col, logic [ELEM_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= IN_DATA_W'({value, col, row});
    do @(posedge clk); while (!in_tready);
    if (req == REQ_LOAD_A) loaded_a[int'(row)*DIM+int'(col)] = 1'b1;
    if (req == REQ_LOAD_B) loaded_b[int'(row)*DIM+int'(col)] = 1'b1;
    if (req != REQ_UNUSED) sent_items++;
  endtask

  // Stops sending and waits until every predicted result has been taken, then lets the
  // core settle. The pending count is read at the falling edge, after the checker has
  // processed the rising edge.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_elems != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each write lowers the write enable again before it returns, so that the enable is never
  // lowered and raised within the same time step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only while the core is idle. The mode write carries random upper
  // bits, which the core has to drop.
  task automatic set_config(logic [SIZE_W-1:0] size_val, logic [MODE_W-1:0] mode_val);
    quiesce();
    write_reg(CFG_MATRIX_SIZE, CFG_DATA_W'(size_val));
    write_reg(CFG_OP_MODE, {2'($urandom_range(0, 3)), mode_val});
  endtask

  // One random phase: new settings, a few stray loads, loads for every element the run
  // will read that is still unset, then one or two runs, each sometimes preceded by an ignored
  // request and followed by loads that queue up behind the run while the core is busy.
  task automatic run_phase(logic [SIZE_W-1:0] size_val, logic [MODE_W-1:0] mode_val);
    int n;
    int span;
    set_config(size_val, mode_val);
    steady_flow = ($urandom_range(0, 3) == 0);
    n = (size_val > DIM) ? DIM : int'(size_val);
    span = (n > 0) ? n : DIM;

    repeat ($urandom_range(0, 4)) begin
      send_req($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A,
               IDX_W'($urandom_range(0, DIM - 1)), IDX_W'($urandom_range(0, DIM - 1)),
               random_elem());
    end

    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!loaded_a[r*DIM+c]) send_req(REQ_LOAD_A, IDX_W'(r), IDX_W'(c), random_elem());
        if (!loaded_b[r*DIM+c]) send_req(REQ_LOAD_B, IDX_W'(r), IDX_W'(c), random_elem());
      end
    end

    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 4) == 0) begin
        send_req(REQ_UNUSED, IDX_W'($urandom()), IDX_W'($urandom()), ELEM_W'($urandom()));
      end
      // The run ignores the data fields, so they carry noise.
      send_req(REQ_RUN, IDX_W'($urandom()), IDX_W'($urandom()), ELEM_W'($urandom()));
      // The first run big enough gets the long output stall while loads keep coming.
      if (!hold_done && n >= 3) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      repeat ($urandom_range(2, 5)) begin
        send_req($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A,
                 IDX_W'($urandom_range(0, span - 1)), IDX_W'($urandom_range(0, span - 1)),
                 random_elem());
      end
    end
  endtask

  // Receiver: bursts of ready separated by random gaps, plus one long stall on request
  // that backs the core up until it stops taking requests.
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("square_matrix_add_sub_mul_core_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A single element first: add wraps past the positive limit.
    set_config(SIZE_W'(1), MODE_ADD);
    send_req(REQ_LOAD_A, '0, '0, ELEM_MAX);
    send_req(REQ_LOAD_B, '0, '0, ELEM_W'(1));
    send_req(REQ_RUN, '0, '0, '0);

    // Subtracting the most negative value from the largest positive one also wraps.
    set_config(SIZE_W'(1), MODE_SUB);
    send_req(REQ_LOAD_B, '0, '0, ELEM_MIN);
    send_req(REQ_RUN, '1, '1, ELEM_NEG1);

    // Multiply of the most negative value by itself; an ignored request goes in between.
    set_config(SIZE_W'(1), MODE_MUL);
    send_req(REQ_LOAD_A, '0, '0, ELEM_MIN);
    send_req(REQ_UNUSED, '1, '1, ELEM_NEG1);
    send_req(REQ_RUN, '0, '0, '0);

    // The unused mode code must behave as add.
    set_config(SIZE_W'(1), MODE_UNUSED);
    send_req(REQ_RUN, '0, '0, '0);

    // A size of zero produces no result at all.
    set_config('0, MODE_ADD);
    send_req(REQ_RUN, '0, '0, '0);

    // A 2x2 product with corner values, plus loads at the highest row and column.
    set_config(SIZE_W'(2), MODE_MUL);
    send_req(REQ_LOAD_A, 3'd0, 3'd0, ELEM_NEG1);
    send_req(REQ_LOAD_A, 3'd0, 3'd1, ELEM_MAX);
    send_req(REQ_LOAD_A, 3'd1, 3'd0, ELEM_MIN);
    send_req(REQ_LOAD_A, 3'd1, 3'd1, '0);
    send_req(REQ_LOAD_B, 3'd0, 3'd0, ELEM_NEG1);
    send_req(REQ_LOAD_B, 3'd0, 3'd1, ELEM_W'(2));
    send_req(REQ_LOAD_B, 3'd1, 3'd0, ELEM_W'(3));
    send_req(REQ_LOAD_B, 3'd1, 3'd1, ELEM_MIN);
    send_req(REQ_LOAD_A, 3'd7, 3'd7, ELEM_NEG1);
    send_req(REQ_LOAD_B, 3'd7, 3'd7, '0);
    send_req(REQ_RUN, '0, '0, '0);

    // Random part, then one phase at full size or above, which saturates to full size.
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      run_phase(pick_size(), MODE_W'($urandom_range(0, 3)));
    end
    run_phase(SIZE_W'($urandom_range(DIM, 15)), MODE_W'($urandom_range(0, 3)));

    quiesce();
    if (mismatch_count == 0) begin
      $display("square_matrix_add_sub_mul_core_tb passed");
    end else begin
      $display("square_matrix_add_sub_mul_core_tb failed");
    end
    $finish;
  end

endmodule

>>> square_matrix_add_sub_mul_core.f
src/sqm_pkg.sv
src/sqm_ram.sv
src/sqm_ctrl.sv
src/sqm_datapath.sv
src/square_matrix_add_sub_mul_core.sv
tb/sv/sqm_result_checker.sv
tb/sv/square_matrix_add_sub_mul_core_tb.sv
